>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset
`define AM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Antecedent implies consequent in the same cycle
`define AM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Antecedent implies consequent in the next cycle
`define AM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define AM_ASSERT(lbl, clk, rst, prop)
`define AM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define AM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/ufrc_pkg.sv
// ----------------------------------------------------------------------------
// ufrc_pkg
// Shared types and constants of the disjoint-set core.
// ----------------------------------------------------------------------------
package ufrc_pkg;

   // element ids and ranks
   localparam int ID_W       = 5;
   localparam int RANK_W     = 3;
   localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;
   localparam logic [ID_W-1:0]   NUM_ELEMENTS_RESET = 5'd31;

   // command codes
   typedef enum logic {
      CMD_UNION = 1'b0,
      CMD_FIND  = 1'b1
   } cmd_type;

   // response status codes
   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_SAME    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   // write enables of the table memories
   typedef struct packed {
      logic parent;
      logic rank;
   } table_we_type;

endpackage

>>> hw/rtl/ufrc_table.sv
// ----------------------------------------------------------------------------
// ufrc_table
// Parent and rank memories: one write port each, one shared registered read.
// ----------------------------------------------------------------------------
module ufrc_table #(
   parameter int DEPTH = 32
) (
   input  logic                            clock,
   input  ufrc_pkg::table_we_type          we,
   input  logic [$clog2(DEPTH)-1:0]        waddr_parent,
   input  logic [$clog2(DEPTH)-1:0]        wdata_parent,
   input  logic [$clog2(DEPTH)-1:0]        waddr_rank,
   input  logic [ufrc_pkg::RANK_W-1:0]     wdata_rank,
   input  logic [$clog2(DEPTH)-1:0]        raddr,
   output logic [$clog2(DEPTH)-1:0]        rdata_parent,
   output logic [ufrc_pkg::RANK_W-1:0]     rdata_rank
);

   localparam int IDX_W = $clog2(DEPTH);

   logic [IDX_W-1:0]           parent_mem [DEPTH];
   logic [ufrc_pkg::RANK_W-1:0] rank_mem  [DEPTH];

   // write ports
   always_ff @(posedge clock) begin
      if (we.parent) begin
         parent_mem[waddr_parent] <= wdata_parent;
      end
      if (we.rank) begin
         rank_mem[waddr_rank] <= wdata_rank;
      end
   end

   // registered read of both memories at one address
   always_ff @(posedge clock) begin
      rdata_parent <= parent_mem[raddr];
      rdata_rank   <= rank_mem[raddr];
   end

endmodule

>>> hw/rtl/union_find_rank_compress_core.sv
// ----------------------------------------------------------------------------
// union_find_rank_compress_core
// Disjoint-set table with union by rank and path compression.
// ----------------------------------------------------------------------------
//  channel   ports                                     handshake
//  request   req_command, req_elem_a, req_elem_b       start & !busy
//  response  rsp_status, rsp_representative            rsp_strobe, one cycle
//  csr       csr_wr_data (num_elements)                csr_wr_en
//
//  A find walks from the element up to its root, then compresses the path;
//  a union does so for both and links the roots unless both share one root.
//  Each link costs a read and a compare in the walk and a read plus a
//  write-back in compression, through one table read port and one comparator.
//  After reset a clearing pass writes every table entry in turn with busy
//  high. Invalid ids answer on the next cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module union_find_rank_compress_core #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [ufrc_pkg::ID_W-1:0]     req_elem_a,
   input  logic [ufrc_pkg::ID_W-1:0]     req_elem_b,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic [ufrc_pkg::ID_W-1:0]     rsp_representative,
   input  logic                          csr_wr_en,
   input  logic [ufrc_pkg::ID_W-1:0]     csr_wr_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [9:0] {
      ST_CLEAR   = 10'b00_0000_0001,
      ST_IDLE    = 10'b00_0000_0010,
      ST_WALK_RD = 10'b00_0000_0100,
      ST_WALK_CK = 10'b00_0000_1000,
      ST_COMP_RD = 10'b00_0001_0000,
      ST_COMP_CK = 10'b00_0010_0000,
      ST_JOIN    = 10'b00_0100_0000,
      ST_RANK_A  = 10'b00_1000_0000,
      ST_RANK_B  = 10'b01_0000_0000,
      ST_LINK    = 10'b10_0000_0000
   } state_type;

   state_type                    state_ff, state_in;
   logic                         cmd_ff, cmd_in;
   logic [ufrc_pkg::ID_W-1:0]    elem_b_ff, elem_b_in;
   logic [IDX_W-1:0]             start_id_ff, start_id_in;
   logic [IDX_W-1:0]             r_ff, r_in;
   logic [IDX_W-1:0]             cur_ff, cur_in;
   logic [IDX_W-1:0]             ra_ff, ra_in;
   logic [ufrc_pkg::RANK_W-1:0]  rka_ff, rka_in;
   logic                         second_ff, second_in;
   logic [IDX_W-1:0]             clr_ff, clr_in;
   logic [ufrc_pkg::ID_W-1:0]    num_ff, num_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;
   logic [ufrc_pkg::ID_W-1:0]    rsp_rep_ff, rsp_rep_in;

   ufrc_pkg::table_we_type       tbl_we;
   logic [IDX_W-1:0]             tbl_waddr_parent;
   logic [IDX_W-1:0]             tbl_wdata_parent;
   logic [IDX_W-1:0]             tbl_waddr_rank;
   logic [ufrc_pkg::RANK_W-1:0]  tbl_wdata_rank;
   logic [IDX_W-1:0]             tbl_raddr;
   logic [IDX_W-1:0]             tbl_rparent;
   logic [ufrc_pkg::RANK_W-1:0]  tbl_rrank;

   logic [IDX_W-1:0]             cmp_lhs;
   logic [IDX_W-1:0]             cmp_rhs;
   logic                         cmp_eq;
   logic                         req_ok;

   ufrc_table #(
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock        (clock),
      .we           (tbl_we),
      .waddr_parent (tbl_waddr_parent),
      .wdata_parent (tbl_wdata_parent),
      .waddr_rank   (tbl_waddr_rank),
      .wdata_rank   (tbl_wdata_rank),
      .raddr        (tbl_raddr),
      .rdata_parent (tbl_rparent),
      .rdata_rank   (tbl_rrank)
   );

   function automatic logic id_ok(input logic [ufrc_pkg::ID_W-1:0] id,
                                  input logic [ufrc_pkg::ID_W-1:0] num);
      return (id != '0) && (id <= num) && (int'(id) < TABLE_DEPTH);
   endfunction

   // validate the incoming command
   always_comb begin
      if (req_command == ufrc_pkg::CMD_FIND) begin
         req_ok = id_ok(req_elem_a, num_ff);
      end else begin
         req_ok = id_ok(req_elem_a, num_ff) && id_ok(req_elem_b, num_ff);
      end
   end

   // steer the shared equality comparator
   always_comb begin
      unique case (state_ff)
         ST_WALK_CK: begin
            cmp_lhs = tbl_rparent;
            cmp_rhs = r_ff;
         end
         ST_JOIN: begin
            cmp_lhs = ra_ff;
            cmp_rhs = r_ff;
         end
         default: begin
            cmp_lhs = cur_ff;
            cmp_rhs = r_ff;
         end
      endcase
   end

   assign cmp_eq = (cmp_lhs == cmp_rhs);

   // sequencer
   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      elem_b_in        = elem_b_ff;
      start_id_in      = start_id_ff;
      r_in             = r_ff;
      cur_in           = cur_ff;
      ra_in            = ra_ff;
      rka_in           = rka_ff;
      second_in        = second_ff;
      clr_in           = clr_ff;
      rsp_strobe_in    = 1'b0;
      rsp_status_in    = rsp_status_ff;
      rsp_rep_in       = rsp_rep_ff;
      tbl_we           = '0;
      tbl_waddr_parent = cur_ff;
      tbl_wdata_parent = r_ff;
      tbl_waddr_rank   = ra_ff;
      tbl_wdata_rank   = tbl_rrank;
      tbl_raddr        = r_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // load identity parents and zero ranks
            tbl_we.parent    = 1'b1;
            tbl_we.rank      = 1'b1;
            tbl_waddr_parent = clr_ff;
            tbl_wdata_parent = clr_ff;
            tbl_waddr_rank   = clr_ff;
            tbl_wdata_rank   = '0;
            clr_in           = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in    = req_command;
               elem_b_in = req_elem_b;
               second_in = 1'b0;
               if (!req_ok) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ufrc_pkg::STATUS_INVALID;
                  rsp_rep_in    = '0;
               end else begin
                  start_id_in = IDX_W'(req_elem_a);
                  r_in        = IDX_W'(req_elem_a);
                  state_in    = ST_WALK_RD;
               end
            end
         end
         ST_WALK_RD: begin
            tbl_raddr = r_ff;
            state_in  = ST_WALK_CK;
         end
         ST_WALK_CK: begin
            // stop at a self-parented entry, else follow the link
            if (cmp_eq) begin
               cur_in   = start_id_ff;
               state_in = ST_COMP_RD;
            end else begin
               r_in     = tbl_rparent;
               state_in = ST_WALK_RD;
            end
         end
         ST_COMP_RD: begin
            if (cmp_eq) begin
               if (cmd_ff == ufrc_pkg::CMD_FIND) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ufrc_pkg::STATUS_DONE;
                  rsp_rep_in    = ufrc_pkg::ID_W'(r_ff);
                  state_in      = ST_IDLE;
               end else if (!second_ff) begin
                  // first root held, walk from the second element
                  ra_in       = r_ff;
                  second_in   = 1'b1;
                  start_id_in = IDX_W'(elem_b_ff);
                  r_in        = IDX_W'(elem_b_ff);
                  state_in    = ST_WALK_RD;
               end else begin
                  state_in = ST_JOIN;
               end
            end else begin
               tbl_raddr = cur_ff;
               state_in  = ST_COMP_CK;
            end
         end
         ST_COMP_CK: begin
            // point the visited entry at the root, advance along the old link
            tbl_we.parent    = 1'b1;
            tbl_waddr_parent = cur_ff;
            tbl_wdata_parent = r_ff;
            cur_in           = tbl_rparent;
            state_in         = ST_COMP_RD;
         end
         ST_JOIN: begin
            if (cmp_eq) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ufrc_pkg::STATUS_SAME;
               rsp_rep_in    = ufrc_pkg::ID_W'(ra_ff);
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_RANK_A;
            end
         end
         ST_RANK_A: begin
            tbl_raddr = ra_ff;
            state_in  = ST_RANK_B;
         end
         ST_RANK_B: begin
            tbl_raddr = r_ff;
            rka_in    = tbl_rrank;
            state_in  = ST_LINK;
         end
         ST_LINK: begin
            // link lower-ranked root under the other; tie: b's root under a's
            tbl_we.parent = 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_status_in = ufrc_pkg::STATUS_DONE;
            state_in      = ST_IDLE;
            priority if (rka_ff < tbl_rrank) begin
               tbl_waddr_parent = ra_ff;
               tbl_wdata_parent = r_ff;
               rsp_rep_in       = ufrc_pkg::ID_W'(r_ff);
            end else if (rka_ff > tbl_rrank) begin
               tbl_waddr_parent = r_ff;
               tbl_wdata_parent = ra_ff;
               rsp_rep_in       = ufrc_pkg::ID_W'(ra_ff);
            end else begin
               tbl_waddr_parent = r_ff;
               tbl_wdata_parent = ra_ff;
               rsp_rep_in       = ufrc_pkg::ID_W'(ra_ff);
               if (rka_ff < ufrc_pkg::RANK_MAX) begin
                  tbl_we.rank    = 1'b1;
                  tbl_waddr_rank = ra_ff;
                  tbl_wdata_rank = rka_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // element count register
   assign num_in = csr_wr_en ? csr_wr_data : num_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         num_ff        <= ufrc_pkg::NUM_ELEMENTS_RESET;
         rsp_strobe_ff <= 1'b0;
         second_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         num_ff        <= num_in;
         rsp_strobe_ff <= rsp_strobe_in;
         second_ff     <= second_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      elem_b_ff     <= elem_b_in;
      start_id_ff   <= start_id_in;
      r_ff          <= r_in;
      cur_ff        <= cur_in;
      ra_ff         <= ra_in;
      rka_ff        <= rka_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rep_ff    <= rsp_rep_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_representative = rsp_rep_ff;

   // checks
   `AM_ASSERT_IMP(a_strobe_ends_cmd, clock, reset, rsp_strobe, !busy && $past(!reset))
   `AM_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe)
   `AM_ASSERT_IMP(a_same_from_union, clock, reset, rsp_strobe && rsp_status == ufrc_pkg::STATUS_SAME, cmd_ff == ufrc_pkg::CMD_UNION)
   `AM_ASSERT_IMP(a_no_write_idle, clock, reset, state_ff == ST_IDLE, tbl_we == '0)

endmodule
